FILE: rtl/core/arm64_instruction_encoder_defines.svh
// assertion macros for the a64 instruction encoder
// used by the top level only, no other dependencies
`ifndef ARM64_INSTRUCTION_ENCODER_DEFINES_SVH
`define ARM64_INSTRUCTION_ENCODER_DEFINES_SVH
`ifndef SYNTHESIS
`define A64ENC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("a64enc check failed");
`define A64ENC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("a64enc check failed");
`else
`define A64ENC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define A64ENC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/a64enc_pkg.sv
// shared types, command codes and opcode constants for the a64 encoder
// no dependencies
`default_nettype none
package a64enc_pkg;

	localparam int A64ENC_COUNT_BITS = 16;
	localparam int Q_DEPTH = 2;
	localparam int MAX_WORDS = 4;
	localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

	typedef enum logic [4:0] {
		CMD_ADD     = 5'd0,
		CMD_SUB     = 5'd1,
		CMD_AND     = 5'd2,
		CMD_ORR     = 5'd3,
		CMD_EOR     = 5'd4,
		CMD_MUL     = 5'd5,
		CMD_MOV     = 5'd6,
		CMD_MVN     = 5'd7,
		CMD_LSL_X   = 5'd8,
		CMD_LSR_X   = 5'd9,
		CMD_LSL_W   = 5'd10,
		CMD_LSR_W   = 5'd11,
		CMD_MOVIMM  = 5'd12,
		CMD_LDR_X   = 5'd13,
		CMD_STR_X   = 5'd14,
		CMD_LDR_W   = 5'd15,
		CMD_STR_W   = 5'd16,
		CMD_CMP     = 5'd17,
		CMD_CSET    = 5'd18,
		CMD_ORRWLSL = 5'd19,
		CMD_RET     = 5'd20,
		CMD_RESTART = 5'd21
	} cmd_e;

	localparam logic [31:0] OPC_ADD    = 32'h8B000000;
	localparam logic [31:0] OPC_SUB    = 32'hCB000000;
	localparam logic [31:0] OPC_AND    = 32'h8A000000;
	localparam logic [31:0] OPC_ORR    = 32'hAA000000;
	localparam logic [31:0] OPC_EOR    = 32'hCA000000;
	localparam logic [31:0] OPC_MADD   = 32'h9B000000;
	localparam logic [31:0] OPC_ORN    = 32'hAA200000;
	localparam logic [31:0] OPC_UBFM_X = 32'hD3400000;
	localparam logic [31:0] OPC_UBFM_W = 32'h53000000;
	localparam logic [31:0] OPC_MOVZ   = 32'hD2800000;
	localparam logic [31:0] OPC_MOVK   = 32'hF2800000;
	localparam logic [31:0] OPC_MOVN   = 32'h92800000;
	localparam logic [31:0] OPC_LDR_X  = 32'hF9400000;
	localparam logic [31:0] OPC_STR_X  = 32'hF9000000;
	localparam logic [31:0] OPC_LDR_W  = 32'hB9400000;
	localparam logic [31:0] OPC_STR_W  = 32'hB9000000;
	localparam logic [31:0] OPC_SUBS   = 32'hEB000000;
	localparam logic [31:0] OPC_CSINC  = 32'h9A800400;
	localparam logic [31:0] OPC_ORR_W  = 32'h2A000000;
	localparam logic [31:0] OPC_RET    = 32'hD65F03C0;
	localparam logic [4:0]  REG_ZR     = 5'd31;

	typedef struct packed {
		logic [4:0]  cmd;
		logic [4:0]  dest_reg;
		logic [4:0]  src_reg_a;
		logic [4:0]  src_reg_b;
		logic [5:0]  shift_amount;
		logic [14:0] byte_offset;
		logic [3:0]  condition;
		logic [63:0] immediate;
	} req_t;

	typedef struct packed {
		logic [31:0] word;
		logic        last;
		logic        dropped;
		logic        overflowed;
	} rsp_t;

	typedef struct packed {
		logic [MAX_WORDS-1:0][31:0] words;
		logic [2:0]                 nwords;
		logic                       restart;
	} job_t;

	typedef struct packed {
		logic                         empty;
		logic                         full;
		logic [$clog2(Q_DEPTH+1)-1:0] count;
	} q_stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/a64enc_front.sv
// front end: classifies each request and builds its list of machine words
// depends on a64enc_pkg
`default_nettype none
module a64enc_front import a64enc_pkg::*; (
	input  wire req_t    req,
	input  wire          req_valid,
	output logic         req_ready,
	input  wire q_stat_t q_stat,
	output logic         push,
	output job_t         push_job
);

	function automatic logic [31:0] dp_word(input logic [31:0] opc, input logic [4:0] rd,
			input logic [4:0] rn, input logic [4:0] rm);
		return opc | (32'(rm) << 16) | (32'(rn) << 5) | 32'(rd);
	endfunction

	function automatic logic [31:0] ubfm_word(input logic [31:0] opc, input logic [4:0] rd,
			input logic [4:0] rn, input logic [5:0] immr, input logic [5:0] imms);
		return opc | (32'(immr) << 16) | (32'(imms) << 10) | (32'(rn) << 5) | 32'(rd);
	endfunction

	function automatic logic [31:0] wide_word(input logic [31:0] opc, input logic [4:0] rd,
			input logic [1:0] hw, input logic [15:0] half);
		return opc | (32'(hw) << 21) | (32'(half) << 5) | 32'(rd);
	endfunction

	function automatic logic [31:0] ldst_word(input logic [31:0] opc, input logic [4:0] rt,
			input logic [4:0] rn, input logic [11:0] imm12);
		return opc | (32'(imm12) << 10) | (32'(rn) << 5) | 32'(rt);
	endfunction

	logic [4:0]  s5;
	logic [2:0]  ones;
	logic        inverted_seq;
	logic [2:0]  n;
	logic [15:0] h;
	logic        known;

	assign s5        = req.shift_amount[4:0];
	assign req_ready = !q_stat.full;
	assign known     = req.cmd inside {[CMD_ADD:CMD_RESTART]};
	assign push      = req_valid && req_ready && known;

	always_comb begin
		push_job = '0;
		push_job.nwords = 3'd1;
		ones = '0;
		inverted_seq = 1'b0;
		n = 3'd1;
		h = '0;
		case (req.cmd)
			CMD_ADD:   push_job.words[0] = dp_word(OPC_ADD, req.dest_reg, req.src_reg_a, req.src_reg_b);
			CMD_SUB:   push_job.words[0] = dp_word(OPC_SUB, req.dest_reg, req.src_reg_a, req.src_reg_b);
			CMD_AND:   push_job.words[0] = dp_word(OPC_AND, req.dest_reg, req.src_reg_a, req.src_reg_b);
			CMD_ORR:   push_job.words[0] = dp_word(OPC_ORR, req.dest_reg, req.src_reg_a, req.src_reg_b);
			CMD_EOR:   push_job.words[0] = dp_word(OPC_EOR, req.dest_reg, req.src_reg_a, req.src_reg_b);
			CMD_MUL: begin
				push_job.words[0] = dp_word(OPC_MADD, req.dest_reg, req.src_reg_a, req.src_reg_b)
					| (32'(REG_ZR) << 10);
			end
			CMD_MOV:   push_job.words[0] = dp_word(OPC_ORR, req.dest_reg, REG_ZR, req.src_reg_b);
			CMD_MVN:   push_job.words[0] = dp_word(OPC_ORN, req.dest_reg, REG_ZR, req.src_reg_b);
			CMD_LSL_X: begin
				push_job.words[0] = ubfm_word(OPC_UBFM_X, req.dest_reg, req.src_reg_a,
					6'(6'd0 - req.shift_amount), ~req.shift_amount);
			end
			CMD_LSR_X: begin
				push_job.words[0] = ubfm_word(OPC_UBFM_X, req.dest_reg, req.src_reg_a,
					req.shift_amount, 6'd63);
			end
			CMD_LSL_W: begin
				push_job.words[0] = ubfm_word(OPC_UBFM_W, req.dest_reg, req.src_reg_a,
					{1'b0, 5'(5'd0 - s5)}, {1'b0, ~s5});
			end
			CMD_LSR_W: begin
				push_job.words[0] = ubfm_word(OPC_UBFM_W, req.dest_reg, req.src_reg_a,
					{1'b0, s5}, 6'd31);
			end
			CMD_MOVIMM: begin
				for (int i = 0; i < MAX_WORDS; i++) begin
					if (req.immediate[16*i +: 16] == 16'hFFFF) begin
						ones = ones + 3'd1;
					end
				end
				inverted_seq = req.immediate[63] && (ones >= 3'd2);
				if (inverted_seq) begin
					push_job.words[0] = wide_word(OPC_MOVN, req.dest_reg, 2'd0,
						~req.immediate[15:0]);
				end else begin
					push_job.words[0] = wide_word(OPC_MOVZ, req.dest_reg, 2'd0,
						req.immediate[15:0]);
				end
				for (int i = 1; i < MAX_WORDS; i++) begin
					h = req.immediate[16*i +: 16];
					if (inverted_seq ? (h != 16'hFFFF) : (h != 16'h0000)) begin
						push_job.words[n[1:0]] = wide_word(OPC_MOVK, req.dest_reg, 2'(i), h);
						n = n + 3'd1;
					end
				end
				push_job.nwords = n;
			end
			CMD_LDR_X: begin
				push_job.words[0] = ldst_word(OPC_LDR_X, req.dest_reg, req.src_reg_a,
					req.byte_offset[14:3]);
			end
			CMD_STR_X: begin
				push_job.words[0] = ldst_word(OPC_STR_X, req.dest_reg, req.src_reg_a,
					req.byte_offset[14:3]);
			end
			CMD_LDR_W: begin
				push_job.words[0] = ldst_word(OPC_LDR_W, req.dest_reg, req.src_reg_a,
					req.byte_offset[13:2]);
			end
			CMD_STR_W: begin
				push_job.words[0] = ldst_word(OPC_STR_W, req.dest_reg, req.src_reg_a,
					req.byte_offset[13:2]);
			end
			CMD_CMP:   push_job.words[0] = dp_word(OPC_SUBS, REG_ZR, req.src_reg_a, req.src_reg_b);
			CMD_CSET: begin
				push_job.words[0] = OPC_CSINC | (32'(REG_ZR) << 16)
					| (32'(req.condition ^ 4'd1) << 12) | (32'(REG_ZR) << 5)
					| 32'(req.dest_reg);
			end
			CMD_ORRWLSL: begin
				push_job.words[0] = OPC_ORR_W | (32'(req.src_reg_b) << 16) | (32'(s5) << 10)
					| (32'(req.src_reg_a) << 5) | 32'(req.dest_reg);
			end
			CMD_RET:   push_job.words[0] = OPC_RET;
			CMD_RESTART: begin
				push_job.restart = 1'b1;
				push_job.nwords = 3'd0;
			end
			default:   push_job.nwords = 3'd0;
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/core/a64enc_queue.sv
// two-entry job queue between the front end and the word emitter
// depends on a64enc_pkg
`default_nettype none
module a64enc_queue import a64enc_pkg::*; (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          push,
	input  wire job_t    push_job,
	input  wire          pop,
	output job_t         head,
	output q_stat_t      stat
);

	localparam int PTR_W = $clog2(Q_DEPTH);
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	job_t             entries_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head       = entries_q[rd_ptr_q];
	assign stat.count = count_q;
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CNT_W'(Q_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/a64enc_back.sv
// back end: emits queued words one per beat, counts them against capacity
// depends on a64enc_pkg
`default_nettype none
module a64enc_back import a64enc_pkg::*; #(
	parameter int COUNT_BITS = A64ENC_COUNT_BITS
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          cfg_valid,
	input  wire  [15:0]  cfg_data,
	input  wire job_t    head,
	input  wire q_stat_t q_stat,
	output logic         pop,
	output rsp_t         rsp,
	output logic         rsp_valid,
	input  wire          rsp_ready
);

	logic [15:0]           capacity_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  overflow_q;
	logic [1:0]            beat_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	logic load_en;
	logic go;
	logic is_last;
	logic fits;

	assign load_en   = !rsp_valid_q || rsp_ready;
	assign go        = !q_stat.empty && load_en;
	assign is_last   = (3'(beat_q) + 3'd1 == head.nwords);
	assign fits      = (32'(count_q) < 32'(capacity_q)) && !(&count_q);
	assign pop       = go && (head.restart || is_last);
	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= CAPACITY_RESET;
			count_q     <= '0;
			overflow_q  <= 1'b0;
			beat_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				capacity_q <= cfg_data;
			end
			if (go) begin
				if (head.restart) begin
					count_q     <= '0;
					overflow_q  <= 1'b0;
					beat_q      <= '0;
					rsp_valid_q <= 1'b0;
				end else begin
					rsp_valid_q <= 1'b1;
					beat_q      <= is_last ? 2'd0 : beat_q + 2'd1;
					if (fits) begin
						count_q <= count_q + 1'b1;
					end else begin
						overflow_q <= 1'b1;
					end
				end
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (go && !head.restart) begin
			rsp_q.word       <= head.words[beat_q];
			rsp_q.last       <= is_last;
			rsp_q.dropped    <= !fits;
			rsp_q.overflowed <= overflow_q || !fits;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/arm64_instruction_encoder.sv
// top level of the a64 instruction encoder: front end, job queue, word emitter
// depends on a64enc_pkg, a64enc_front, a64enc_queue, a64enc_back and the defines header
// Each request goes in through req; the front end encodes it in the cycle of its transfer and
// queues one to four words; the emitter sends them on rsp, one word per cycle while rsp_ready
// allows, from a queue entry through an output register. Requests that give one word sustain
// one per cycle unless rsp stalls; a 64-bit immediate load holds the emitter for all its one to
// four words, and the two-entry queue fills while it does. Restart gives no word; unused command
// codes are dropped at the front end. The capacity register is to be written through cfg by the
// user only while the block is idle; the block does not enforce this. The register resets to
// 65535, the word count saturates at its maximum, and there is no clearing pass after reset.
`default_nettype none
`include "arm64_instruction_encoder_defines.svh"
module arm64_instruction_encoder import a64enc_pkg::*; #(
	parameter int COUNT_BITS = A64ENC_COUNT_BITS
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [15:0] cfg_data,
	input  wire req_t   req,
	input  wire         req_valid,
	output logic        req_ready,
	output rsp_t        rsp,
	output logic        rsp_valid,
	input  wire         rsp_ready
);

	q_stat_t q_stat;
	logic    push;
	job_t    push_job;
	logic    pop;
	job_t    head;

	assign cfg_ready = 1'b1;

	a64enc_front u_front (
		.req       (req),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.q_stat    (q_stat),
		.push      (push),
		.push_job  (push_job)
	);

	a64enc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	a64enc_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready)
	);

	`A64ENC_ASSERT_SAME(a_drop_sets_flag, clk, arst_n, rsp_valid && rsp.dropped, rsp.overflowed)
	`A64ENC_ASSERT_SAME(a_no_push_when_full, clk, arst_n, q_stat.full, !push)
	`A64ENC_ASSERT_SAME(a_no_pop_when_empty, clk, arst_n, q_stat.empty, !pop)
	`A64ENC_ASSERT_NEXT(a_restart_clears_flag, clk, arst_n, pop && head.restart, !rsp_valid)

endmodule
`default_nettype wire
